[rtl/mpa_pkg.sv]
// ----------------------------------------------------------------------------
// mpa_pkg
// Types and constants shared by the mouse packet assembler modules.
// ----------------------------------------------------------------------------
package mpa_pkg;

	localparam int unsigned DATA_W        = 8;
	localparam int unsigned IN_TICK_W     = 32;
	localparam int unsigned LIMIT_W       = 16;
	localparam int unsigned COUNT_W       = 32;
	localparam int unsigned DELTA_W       = 9;
	localparam int unsigned BUTTON_W      = 3;

	localparam int unsigned SYNC_BIT      = 3;
	localparam int unsigned X_SIGN_BIT    = 4;
	localparam int unsigned Y_SIGN_BIT    = 5;

	localparam logic [LIMIT_W-1:0] GAP_LIMIT_RESET = 16'd25;

	localparam int unsigned CFG_ADDR_W    = 3;
	localparam logic        REG_GAP_LIMIT = 1'b0;

	typedef enum logic [1:0] {
		POS_HEADER = 2'd0,
		POS_X      = 2'd1,
		POS_Y      = 2'd2
	} pos_t;

	typedef struct packed {
		logic                       packet_done;
		logic signed [DELTA_W-1:0]  delta_x;
		logic signed [DELTA_W-1:0]  delta_y;
		logic [BUTTON_W-1:0]        button_bits;
		logic                       gap_resync;
		logic                       framing_error;
		logic [COUNT_W-1:0]         packet_total;
		logic [COUNT_W-1:0]         sync_error_total;
	} mpa_result_t;

endpackage

[rtl/mpa_framer.sv]
// ----------------------------------------------------------------------------
// mpa_framer
// Packet framing state, timeout check and result formation for one byte.
// ----------------------------------------------------------------------------
module mpa_framer
	import mpa_pkg::*;
#(
	parameter int unsigned TICK_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [DATA_W-1:0]     data_byte,
	input  logic [IN_TICK_W-1:0]  arrival_tick,
	input  logic [LIMIT_W-1:0]    gap_limit,
	output mpa_result_t           result
);

	localparam int unsigned CMP_W = (TICK_BITS > LIMIT_W) ? TICK_BITS : LIMIT_W;

	pos_t                  pos_q;
	logic [DATA_W-1:0]     header_q;
	logic [DATA_W-1:0]     x_byte_q;
	logic [TICK_BITS-1:0]  prev_tick_q;
	logic [COUNT_W-1:0]    packet_cnt_q;
	logic [COUNT_W-1:0]    error_cnt_q;

	pos_t                  pos_cur;
	pos_t                  pos_aft;
	pos_t                  pos_nxt;
	logic [TICK_BITS-1:0]  tick;
	logic [TICK_BITS-1:0]  gap;
	logic                  timeout;
	logic                  framing;
	logic                  done;
	logic                  take_header;
	logic                  take_x;
	logic [COUNT_W-1:0]    packet_cnt_nxt;
	logic [COUNT_W-1:0]    error_cnt_nxt;

	always_comb begin
		unique case (pos_q)
			POS_X:   pos_cur = POS_X;
			POS_Y:   pos_cur = POS_Y;
			default: pos_cur = POS_HEADER;
		endcase
		tick    = TICK_BITS'(arrival_tick);
		gap     = tick - prev_tick_q;
		timeout = (pos_cur != POS_HEADER) && (CMP_W'(gap) > CMP_W'(gap_limit));
		pos_aft = timeout ? POS_HEADER : pos_cur;
		framing = (pos_aft == POS_HEADER) && !data_byte[SYNC_BIT];
		take_header = (pos_aft == POS_HEADER) && data_byte[SYNC_BIT];
		take_x      = (pos_aft == POS_X);
		done        = (pos_aft == POS_Y);
		unique case (pos_aft)
			POS_HEADER: pos_nxt = framing ? POS_HEADER : POS_X;
			POS_X:      pos_nxt = POS_Y;
			default:    pos_nxt = POS_HEADER;
		endcase
		packet_cnt_nxt = packet_cnt_q + COUNT_W'(done);
		error_cnt_nxt  = error_cnt_q + COUNT_W'(timeout) + COUNT_W'(framing);
	end

	always_comb begin
		result                  = '0;
		result.packet_done      = done;
		result.gap_resync       = timeout;
		result.framing_error    = framing;
		result.packet_total     = packet_cnt_nxt;
		result.sync_error_total = error_cnt_nxt;
		if (done) begin
			result.delta_x     = {header_q[X_SIGN_BIT], x_byte_q};
			result.delta_y     = {header_q[Y_SIGN_BIT], data_byte};
			result.button_bits = header_q[BUTTON_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= POS_HEADER;
			header_q     <= '0;
			x_byte_q     <= '0;
			prev_tick_q  <= '0;
			packet_cnt_q <= '0;
			error_cnt_q  <= '0;
		end else if (step) begin
			pos_q        <= pos_nxt;
			prev_tick_q  <= tick;
			packet_cnt_q <= packet_cnt_nxt;
			error_cnt_q  <= error_cnt_nxt;
			if (take_header) begin
				header_q <= data_byte;
			end
			if (take_x) begin
				x_byte_q <= data_byte;
			end
		end
	end

endmodule

[rtl/mouse_packet_assembler_unit.sv]
// ----------------------------------------------------------------------------
// mouse_packet_assembler_unit
// Assembles three-byte mouse packets from a stream of received bytes.
// ----------------------------------------------------------------------------
// Each accepted byte yields exactly one result. The block takes one byte per
// clock cycle when the output side keeps up; a byte passes an input register
// and a result register before its result is on the output. The framing
// logic between those registers is a single tick subtract and compare.
// gap_limit (byte address 0) resets to 25 and should only be written while
// no bytes are in flight.
module mouse_packet_assembler_unit
	import mpa_pkg::*;
#(
	parameter int unsigned TICK_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// data_byte[7:0], arrival_tick[39:8]
	input  logic [39:0]            s_axis_tdata,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// delta_x[8:0], delta_y[17:9], button_bits[20:18], packet_total[52:21],
	// sync_error_total[84:53], zero fill[87:85]
	output logic [87:0]            m_axis_tdata,
	// packet_done[0], gap_resync[1], framing_error[2]
	output logic [2:0]             m_axis_tuser,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [CFG_ADDR_W-1:0]  paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	logic                  valid_s1;
	logic [DATA_W-1:0]     data_s1;
	logic [IN_TICK_W-1:0]  tick_s1;
	logic                  valid_s2;
	logic [87:0]           tdata_s2;
	logic [2:0]            tuser_s2;
	logic [LIMIT_W-1:0]    gap_limit_q;
	logic                  advance;
	logic                  in_take;
	logic                  cfg_write;
	mpa_result_t           result;

	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign in_take       = s_axis_tvalid && s_axis_tready;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_GAP_LIMIT) begin
			prdata = 32'(gap_limit_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_limit_q <= GAP_LIMIT_RESET;
		end else if (cfg_write && paddr[2] == REG_GAP_LIMIT) begin
			gap_limit_q <= pwdata[LIMIT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			data_s1 <= s_axis_tdata[DATA_W-1:0];
			tick_s1 <= s_axis_tdata[DATA_W +: IN_TICK_W];
		end
	end

	mpa_framer #(
		.TICK_BITS (TICK_BITS)
	) u_framer (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.data_byte    (data_s1),
		.arrival_tick (tick_s1),
		.gap_limit    (gap_limit_q),
		.result       (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_axis_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			tdata_s2 <= {3'b000, result.sync_error_total, result.packet_total,
				result.button_bits, result.delta_y, result.delta_x};
			tuser_s2 <= {result.framing_error, result.gap_resync, result.packet_done};
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = tdata_s2;
	assign m_axis_tuser  = tuser_s2;

endmodule

[bench/mouse_packet_assembler_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mouse_packet_assembler_unit_test
// Streams mouse bytes with arrival ticks into the assembler and checks each
// result against an in-bench assembly model or a directed row's known value.
// Directed rows cover framing, timeout, sign extension and tick wrap; random
// phases use several gap limits, most with random idling on both sides.
// ----------------------------------------------------------------------------
module mouse_packet_assembler_unit_test;
	import mpa_pkg::*;

	localparam int unsigned QUIET_LIMIT = 2000;
	localparam int unsigned DRAIN_CYCLES = 4;
	localparam logic [CFG_ADDR_W-1:0] GAP_LIMIT_ADDR = CFG_ADDR_W'(4 * REG_GAP_LIMIT);

	typedef struct {
		logic [DATA_W-1:0]    data;
		logic [IN_TICK_W-1:0] tick;
		bit                   known;
		mpa_result_t          result;
	} dir_row_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic [39:0]           s_axis_tdata = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [87:0]           m_axis_tdata;
	logic [2:0]            m_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [31:0]           pwdata = '0;
	logic [31:0]           prdata;
	logic                  pready;

	// packet assembly model state
	logic [LIMIT_W-1:0]   gap_lim = GAP_LIMIT_RESET;
	pos_t                 byte_pos = POS_HEADER;
	logic [DATA_W-1:0]    hdr_val = '0;
	logic [DATA_W-1:0]    x_val = '0;
	logic [IN_TICK_W-1:0] prev_tick = '0;
	logic [COUNT_W-1:0]   pkt_total = '0;
	logic [COUNT_W-1:0]   err_total = '0;

	mpa_result_t          pending_results[$];
	dir_row_t             dir_rows[24];
	logic [IN_TICK_W-1:0] now_tick = '0;
	int                   idle_pct = 0;
	int                   stall_left = 0;
	int                   quiet_cycles = 0;
	int                   mismatch_count = 0;
	int                   result_index = 0;
	int                   bytes_sent = 0;
	int                   limit_settings = 1;

	mouse_packet_assembler_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic mpa_result_t known_result(bit done, int dx, int dy, int btn,
			bit resync, bit framing, int pkts, int errs);
		mpa_result_t r;
		r.packet_done      = done;
		r.delta_x          = DELTA_W'(dx);
		r.delta_y          = DELTA_W'(dy);
		r.button_bits      = BUTTON_W'(btn);
		r.gap_resync       = resync;
		r.framing_error    = framing;
		r.packet_total     = COUNT_W'(pkts);
		r.sync_error_total = COUNT_W'(errs);
		return r;
	endfunction

	function automatic mpa_result_t assemble_byte(logic [DATA_W-1:0] b, logic [IN_TICK_W-1:0] t);
		mpa_result_t          r;
		logic [IN_TICK_W-1:0] gap;
		r = '0;
		gap = t - prev_tick;
		if (byte_pos != POS_HEADER && gap > IN_TICK_W'(gap_lim)) begin
			err_total += 1;
			r.gap_resync = 1'b1;
			byte_pos = POS_HEADER;
		end
		prev_tick = t;
		if (byte_pos == POS_HEADER) begin
			if (!b[SYNC_BIT]) begin
				err_total += 1;
				r.framing_error = 1'b1;
			end else begin
				hdr_val = b;
				byte_pos = POS_X;
			end
		end else if (byte_pos == POS_X) begin
			x_val = b;
			byte_pos = POS_Y;
		end else begin
			byte_pos = POS_HEADER;
			pkt_total += 1;
			r.packet_done = 1'b1;
			r.delta_x     = {hdr_val[X_SIGN_BIT], x_val};
			r.delta_y     = {hdr_val[Y_SIGN_BIT], b};
			r.button_bits = hdr_val[BUTTON_W-1:0];
		end
		r.packet_total     = pkt_total;
		r.sync_error_total = err_total;
		return r;
	endfunction

	function automatic logic [IN_TICK_W-1:0] next_gap();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return IN_TICK_W'(gap_lim) + 1;
			2: return IN_TICK_W'(gap_lim);
			default: return $urandom_range(0, gap_lim);
		endcase
	endfunction

	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
		$display("mismatch in %s at result %0d: got %0h, wanted %0h",
			field, result_index, got, want);
		mismatch_count++;
	endtask

	task automatic compare_result(mpa_result_t got);
		mpa_result_t want;
		if (pending_results.size() == 0) begin
			report_mismatch("result with no request pending", 0, 0);
			return;
		end
		want = pending_results.pop_front();
		if (got.packet_done !== want.packet_done)
			report_mismatch("packet_done", 32'(got.packet_done), 32'(want.packet_done));
		if (got.delta_x !== want.delta_x)
			report_mismatch("delta_x", 32'(got.delta_x), 32'(want.delta_x));
		if (got.delta_y !== want.delta_y)
			report_mismatch("delta_y", 32'(got.delta_y), 32'(want.delta_y));
		if (got.button_bits !== want.button_bits)
			report_mismatch("button_bits", 32'(got.button_bits), 32'(want.button_bits));
		if (got.gap_resync !== want.gap_resync)
			report_mismatch("gap_resync", 32'(got.gap_resync), 32'(want.gap_resync));
		if (got.framing_error !== want.framing_error)
			report_mismatch("framing_error", 32'(got.framing_error),
				32'(want.framing_error));
		if (got.packet_total !== want.packet_total)
			report_mismatch("packet_total", got.packet_total, want.packet_total);
		if (got.sync_error_total !== want.sync_error_total)
			report_mismatch("sync_error_total", got.sync_error_total, want.sync_error_total);
	endtask

	// check results, pace the result side, watch for a hang
	always @(posedge clk) begin
		mpa_result_t got;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.delta_x          = m_axis_tdata[8:0];
				got.delta_y          = m_axis_tdata[17:9];
				got.button_bits      = m_axis_tdata[20:18];
				got.packet_total     = m_axis_tdata[52:21];
				got.sync_error_total = m_axis_tdata[84:53];
				got.packet_done      = m_axis_tuser[0];
				got.gap_resync       = m_axis_tuser[1];
				got.framing_error    = m_axis_tuser[2];
				compare_result(got);
				result_index++;
			end
			if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
				m_axis_tready <= 1'b0;
				stall_left = $urandom_range(1, 11) - 1;
			end else begin
				m_axis_tready <= 1'b1;
			end
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("no request moved for %0d cycles", QUIET_LIMIT);
				$display("status: fail");
				$finish;
			end
		end
	end

	task automatic send_byte(logic [DATA_W-1:0] b, logic [IN_TICK_W-1:0] t, bit known,
			mpa_result_t known_res);
		mpa_result_t predicted;
		if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_axis_tdata  <= {t, b};
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predicted = assemble_byte(b, t);
		pending_results.push_back(known ? known_res : predicted);
		now_tick = t;
		bytes_sent++;
	endtask

	task automatic send_next(logic [DATA_W-1:0] b);
		send_byte(b, now_tick + next_gap(), 1'b0, '0);
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_gap_limit(logic [LIMIT_W-1:0] value);
		wait_idle();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= GAP_LIMIT_ADDR;
		pwdata  <= {16'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		gap_lim = value;
		limit_settings++;
	endtask

	task automatic random_phase(int n);
		int sent;
		int len;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(0, 4) != 0) begin
				// mostly whole packets, sometimes cut short
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 3;
				send_next(8'($urandom) | 8'h08);
				for (int k = 1; k < len; k++)
					send_next(8'($urandom));
				sent += len;
			end else begin
				send_next(8'($urandom));
				sent++;
			end
		end
	endtask

	initial begin
		logic [LIMIT_W-1:0] limits[5];
		int                 counts[5];
		int                 idles[5];

		dir_rows = '{
			'{8'h00, 32'h0000_0000, 1'b1, known_result(0, 0, 0, 0, 0, 1, 0, 1)},
			'{8'hFF, 32'hFFFF_FFF0, 1'b1, known_result(0, 0, 0, 0, 0, 0, 0, 1)},
			'{8'hFF, 32'h0000_0005, 1'b0, '0},
			'{8'hFF, 32'h0000_0014, 1'b1, known_result(1, -1, -1, 7, 0, 0, 1, 1)},
			'{8'h08, 32'h0000_0100, 1'b0, '0},
			'{8'h00, 32'h0000_0119, 1'b0, '0},
			'{8'h00, 32'h0000_0132, 1'b0, '0},
			'{8'h38, 32'h0000_0200, 1'b0, '0},
			'{8'h00, 32'h0000_021A, 1'b1, known_result(0, 0, 0, 0, 1, 1, 2, 3)},
			'{8'h09, 32'h0000_0300, 1'b0, '0},
			'{8'h88, 32'h0000_031A, 1'b1, known_result(0, 0, 0, 0, 1, 0, 2, 4)},
			'{8'h7F, 32'h0000_0320, 1'b0, '0},
			'{8'h80, 32'h0000_0330, 1'b0, '0},
			'{8'h1A, 32'h0000_0400, 1'b0, '0},
			'{8'h00, 32'h0000_0401, 1'b0, '0},
			'{8'hFF, 32'h0000_0402, 1'b1, known_result(1, -256, 255, 2, 0, 0, 4, 4)},
			'{8'h2C, 32'h0000_0500, 1'b0, '0},
			'{8'hFF, 32'h0000_0500, 1'b0, '0},
			'{8'h00, 32'h0000_0519, 1'b1, known_result(1, 255, -256, 4, 0, 0, 5, 4)},
			'{8'h08, 32'hFFFF_FFFF, 1'b0, '0},
			'{8'h08, 32'h0000_0000, 1'b0, '0},
			'{8'h08, 32'hFFFF_FFFE, 1'b1, known_result(0, 0, 0, 0, 1, 0, 5, 5)},
			'{8'hF7, 32'hFFFF_FFFE, 1'b0, '0},
			'{8'hF7, 32'h0000_0018, 1'b1, known_result(0, 0, 0, 0, 1, 1, 5, 7)}
		};
		limits = '{16'h0000, 16'hFFFF, 16'($urandom_range(1, 64)), 16'($urandom), 16'($urandom)};
		counts = '{150, 150, 150, 150, 250};
		idles  = '{20, 10, 35, 0, 0};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct = 15;
		foreach (dir_rows[i])
			send_byte(dir_rows[i].data, dir_rows[i].tick, dir_rows[i].known, dir_rows[i].result);

		for (int p = 0; p < 5; p++) begin
			write_gap_limit(limits[p]);
			idle_pct = idles[p];
			random_phase(counts[p]);
		end

		wait_idle();
		$display("sent %0d bytes under %0d gap limit settings", bytes_sent, limit_settings);
		$display("saw %0d packets and %0d sync errors, %0d mismatches",
			pkt_total, err_total, mismatch_count);
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

[mouse_packet_assembler_unit.f]
rtl/mpa_pkg.sv
rtl/mpa_framer.sv
rtl/mouse_packet_assembler_unit.sv
bench/mouse_packet_assembler_unit_test.sv
